### design/assert_macros.svh
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

### design/t9wpm_pkg.sv
// ----------------------------------------------------------------------------
// t9wpm_pkg
// Types, codes and the keypad table of the T9 word prefix matcher.
// ----------------------------------------------------------------------------
package t9wpm_pkg;

  localparam int unsigned POS_W      = 9;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned MAX_SEARCH = 16;
  localparam int unsigned MAX_TEXT   = 256;

  // raw UTF-16 codes, and the code page bytes of YO
  localparam logic [15:0] CHAR_SPACE = 16'h0020;
  localparam logic [15:0] CHAR_PLUS  = 16'h002B;
  localparam logic [15:0] CYR_LO     = 16'h0410;
  localparam logic [15:0] CYR_HI     = 16'h0450;
  localparam logic [15:0] CYR_OFS    = 16'h0350;
  localparam logic [15:0] YO_UPPER   = 16'h0401;
  localparam logic [15:0] YO_LOWER   = 16'h0451;
  localparam logic [7:0]  YO_UPPER_CP = 8'hA8;
  localparam logic [7:0]  YO_LOWER_CP = 8'hB8;

  // keypad symbols
  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_1    = 8'h31;
  localparam logic [7:0] KEY_2    = 8'h32;
  localparam logic [7:0] KEY_3    = 8'h33;
  localparam logic [7:0] KEY_4    = 8'h34;
  localparam logic [7:0] KEY_5    = 8'h35;
  localparam logic [7:0] KEY_6    = 8'h36;
  localparam logic [7:0] KEY_7    = 8'h37;
  localparam logic [7:0] KEY_8    = 8'h38;
  localparam logic [7:0] KEY_9    = 8'h39;
  localparam logic [7:0] KEY_STAR = 8'h2A;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SEARCH_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SEARCH_CHARS_A = 2'd1;
  localparam logic [1:0] REG_SEARCH_CHARS_B = 2'd2;

  // classified character, front to back
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             is_plus;
    logic             is_space;
    logic             first;
    logic             last;
  } cls_t;

  // one result request
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] hit_start;
    logic [POS_W-1:0] hit_end;
    logic             string_done;
  } res_t;

  // Fold Cyrillic into the 8-bit code page, keep the low byte.
  function automatic logic [7:0] fold_char(input logic [15:0] c);
    logic [15:0] t;
    t = c;
    if (c >= CYR_LO && c < CYR_HI) t = c - CYR_OFS;
    if (c == YO_UPPER) t = {8'h00, YO_UPPER_CP};
    if (c == YO_LOWER) t = {8'h00, YO_LOWER_CP};
    return t[7:0];
  endfunction

  // Phone keypad symbol of a code page character.
  function automatic logic [7:0] keypad_sym(input logic [7:0] c);
    logic [7:0] k;
    logic [4:0] ofs;
    ofs = c[4:0];
    k   = KEY_1;
    case (c) inside
      [8'd33:8'd35], 8'd39, [8'd43:8'd46], 8'd48, 8'd58, 8'd59, 8'd63, 8'd64,
      8'd95: k = KEY_0;
      [8'd37:8'd38], [8'd40:8'd42], 8'd47, [8'd60:8'd62], 8'd92,
      8'd126: k = KEY_STAR;
      8'd50, [8'd65:8'd67], [8'd97:8'd99]: k = KEY_2;
      8'd51, [8'd68:8'd70], [8'd100:8'd102], 8'd168, 8'd184: k = KEY_3;
      8'd52, [8'd71:8'd73], [8'd103:8'd105]: k = KEY_4;
      8'd53, [8'd74:8'd76], [8'd106:8'd108]: k = KEY_5;
      8'd54, [8'd77:8'd79], [8'd109:8'd111]: k = KEY_6;
      8'd55, [8'd80:8'd83], [8'd112:8'd115]: k = KEY_7;
      8'd56, [8'd84:8'd86], [8'd116:8'd118]: k = KEY_8;
      8'd57, [8'd87:8'd90], [8'd119:8'd122]: k = KEY_9;
      [8'd192:8'd255]: begin
        case (ofs) inside
          [5'd0:5'd3]:   k = KEY_2;
          [5'd4:5'd7]:   k = KEY_3;
          [5'd8:5'd11]:  k = KEY_4;
          [5'd12:5'd14]: k = KEY_5;
          [5'd15:5'd17]: k = KEY_6;
          [5'd18:5'd21]: k = KEY_7;
          [5'd22:5'd26]: k = KEY_8;
          default:       k = KEY_9;
        endcase
      end
      default: k = KEY_1;
    endcase
    return k;
  endfunction

endpackage

### design/t9_word_prefix_matcher.sv
// ----------------------------------------------------------------------------
// t9_word_prefix_matcher
// Keypad-digit prefix search over the words of a UTF-16 name string.
// ----------------------------------------------------------------------------
// Push the characters of one string, first_char_i marking the first and
// last_char_i the last; pop one verdict request for every character. The
// verdict is sticky within a string: hit_o rises once the configured digit
// string has matched at the start of the string or of a word after a space,
// and hit_start_o / hit_end_o give the 1-based positions of that match. A
// sustained rate of one character per cycle is kept from push to pop while
// the consumer pops. The front classifies a character combinationally into
// a short queue; the back updates the match state once per character, and
// that state loop sets the rate. A character is registered in the middle
// queue, its verdict in the verdict queue. No clearing pass runs after reset.
`include "assert_macros.svh"

module t9_word_prefix_matcher import t9wpm_pkg::*; #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // character queue
  input  logic             push,
  output logic             full,
  input  logic [15:0]      text_char_i,
  input  logic             first_char_i,
  input  logic             last_char_i,
  // verdict queue
  output logic             empty,
  input  logic             pop,
  output logic             hit_o,
  output logic [POS_W-1:0] hit_start_o,
  output logic [POS_W-1:0] hit_end_o,
  output logic             string_done_o
);

  localparam int unsigned CLS_W = $bits(cls_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic [LEN_W-1:0] search_length_q;
  logic [63:0]      search_chars_a_q;
  logic [63:0]      search_chars_b_q;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  cls_t             mid_cls_in, mid_cls_out;
  logic             out_push, out_full;
  res_t             out_res_in, out_res_out;

  // --- configuration registers, 8-byte stride ---
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_length_q  <= '0;
      search_chars_a_q <= '0;
      search_chars_b_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SEARCH_LENGTH:  search_length_q  <= pwdata[LEN_W-1:0];
        REG_SEARCH_CHARS_A: search_chars_a_q <= pwdata;
        REG_SEARCH_CHARS_B: search_chars_b_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEARCH_LENGTH:  prdata = {{(64 - LEN_W){1'b0}}, search_length_q};
      REG_SEARCH_CHARS_A: prdata = search_chars_a_q;
      REG_SEARCH_CHARS_B: prdata = search_chars_b_q;
      default:            prdata = '0;
    endcase
  end

  // --- front: accept and classify ---
  t9wpm_front u_front (
    .push         (push),
    .full         (full),
    .text_char_i  (text_char_i),
    .first_char_i (first_char_i),
    .last_char_i  (last_char_i),
    .mid_full_i   (mid_full),
    .mid_push_o   (mid_push),
    .mid_cls_o    (mid_cls_in)
  );

  // --- queue between front and back ---
  t9wpm_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_cls_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_cls_out),
    .empty_o (mid_empty)
  );

  // --- back: match state ---
  t9wpm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .search_length_i  (search_length_q),
    .search_chars_a_i (search_chars_a_q),
    .search_chars_b_i (search_chars_b_q),
    .mid_empty_i      (mid_empty),
    .mid_cls_i        (mid_cls_out),
    .mid_pop_o        (mid_pop),
    .out_full_i       (out_full),
    .out_push_o       (out_push),
    .out_res_o        (out_res_in)
  );

  // --- verdict queue: hold results while the consumer stalls ---
  t9wpm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res_out),
    .empty_o (empty)
  );

  assign hit_o         = out_res_out.hit;
  assign hit_start_o   = out_res_out.hit_start;
  assign hit_end_o     = out_res_out.hit_end;
  assign string_done_o = out_res_out.string_done;

  // --- checks ---
  `ASSERT_CLK(a_nohit_zero_pos, (!empty && !hit_o) |-> (hit_start_o == '0 && hit_end_o == '0), "positions set without a hit")
  `ASSERT_CLK(a_start_le_end, (!empty && hit_o && hit_start_o != '0) |-> (hit_start_o <= hit_end_o), "match start after match end")
  `ASSERT_NEVER(a_back_move_ok, (mid_pop || out_push) && (mid_empty || out_full), "back moved a request without room")

endmodule

### design/t9wpm_fifo.sv
// ----------------------------------------------------------------------------
// t9wpm_fifo
// Small register queue with same-cycle push and pop.
// ----------------------------------------------------------------------------
module t9wpm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    if (do_pop && !do_push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### design/t9wpm_front.sv
// ----------------------------------------------------------------------------
// t9wpm_front
// Accept characters, fold them and look up their keypad symbol.
// ----------------------------------------------------------------------------
module t9wpm_front import t9wpm_pkg::*; (
  input  logic        push,
  output logic        full,
  input  logic [15:0] text_char_i,
  input  logic        first_char_i,
  input  logic        last_char_i,
  input  logic        mid_full_i,
  output logic        mid_push_o,
  output cls_t        mid_cls_o
);

  assign full       = mid_full_i;
  assign mid_push_o = push && !mid_full_i;

  always_comb begin
    mid_cls_o.sym      = keypad_sym(fold_char(text_char_i));
    mid_cls_o.is_plus  = (text_char_i == CHAR_PLUS);
    mid_cls_o.is_space = (text_char_i == CHAR_SPACE);
    mid_cls_o.first    = first_char_i;
    mid_cls_o.last     = last_char_i;
  end

endmodule

### design/t9wpm_back.sv
// ----------------------------------------------------------------------------
// t9wpm_back
// Match state: advance through the search string one character a cycle while the queues allow.
// ----------------------------------------------------------------------------
module t9wpm_back import t9wpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] search_length_i,
  input  logic [63:0]      search_chars_a_i,
  input  logic [63:0]      search_chars_b_i,
  input  logic             mid_empty_i,
  input  cls_t             mid_cls_i,
  output logic             mid_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output res_t             out_res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] midx_q, midx_d;
  logic [POS_W-1:0] pstart_q, pstart_d;
  logic             hflag_q, hflag_d;
  logic [POS_W-1:0] hbeg_q, hbeg_d;
  logic [POS_W-1:0] hend_q, hend_d;

  logic             fire;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] midx_m1;
  logic [3:0]       sidx;
  logic [127:0]     chars;
  logic [SYM_W-1:0] ref_sym;

  assign fire       = !mid_empty_i && !out_full_i;
  assign mid_pop_o  = fire;
  assign out_push_o = fire;
  assign chars      = {search_chars_b_i, search_chars_a_i};
  assign len        = (search_length_i > LEN_W'(MAX_SEARCH)) ? LEN_W'(MAX_SEARCH)
                                                             : search_length_i;

  always_comb begin
    pos_d    = pos_q;
    midx_d   = midx_q;
    pstart_d = pstart_q;
    hflag_d  = hflag_q;
    hbeg_d   = hbeg_q;
    hend_d   = hend_q;
    // restart on the first character of a string
    if (mid_cls_i.first) begin
      pos_d    = '0;
      midx_d   = LEN_W'(1);
      pstart_d = '0;
      hflag_d  = 1'b0;
      hbeg_d   = '0;
      hend_d   = '0;
    end
    midx_m1 = midx_d - LEN_W'(1);
    sidx    = midx_m1[3:0];
    ref_sym = chars[{sidx, 3'b000} +: SYM_W];
    // ignore characters past the end of the text window
    if (pos_d < POS_W'(MAX_TEXT)) begin
      pos_d = pos_d + POS_W'(1);
      if (!hflag_d) begin
        if (len == '0) begin
          hflag_d = 1'b1;
          hbeg_d  = '0;
          hend_d  = '0;
        end else if (pos_d == POS_W'(1) && mid_cls_i.is_plus) begin
          // skip a leading plus
        end else if (midx_d == '0) begin
          if (mid_cls_i.is_space) midx_d = LEN_W'(1);
        end else if (mid_cls_i.sym == ref_sym) begin
          if (pstart_d == '0) pstart_d = pos_d;
          midx_d = midx_d + LEN_W'(1);
          if (midx_d > len) begin
            hflag_d = 1'b1;
            hbeg_d  = pstart_d;
            hend_d  = pos_d;
          end
        end else begin
          pstart_d = '0;
          midx_d   = '0;
        end
      end
    end
    out_res_o.hit         = hflag_d;
    out_res_o.hit_start   = hbeg_d;
    out_res_o.hit_end     = hend_d;
    out_res_o.string_done = mid_cls_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      midx_q   <= '0;
      pstart_q <= '0;
      hflag_q  <= 1'b0;
      hbeg_q   <= '0;
      hend_q   <= '0;
    end else if (fire) begin
      pos_q    <= pos_d;
      midx_q   <= midx_d;
      pstart_q <= pstart_d;
      hflag_q  <= hflag_d;
      hbeg_q   <= hbeg_d;
      hend_q   <= hend_d;
    end
  end

endmodule
